[rtl/edc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and register indexes of the envelope dynamic compressor.
// Depends on nothing; every other file of the block imports it.
package edc_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int WEIGHT_BITS = 16;
   localparam int ENV_FRAC    = 16;
   localparam int MAG_BITS    = SAMPLE_BITS - 1;
   localparam int ABS_BITS    = SAMPLE_BITS + 1;
   localparam int ENV_BITS    = MAG_BITS + ENV_FRAC;
   localparam int WPROD_BITS  = WEIGHT_BITS + ENV_BITS;
   localparam int MPROD_BITS  = WEIGHT_BITS + 1 + MAG_BITS;
   localparam int NUM_BITS    = ABS_BITS + ENV_BITS;
   localparam int DIV_STEPS   = ABS_BITS;
   localparam int DCNT_BITS   = $clog2(DIV_STEPS);
   localparam int FIFO_DEPTH  = 2;
   localparam int FPTR_BITS   = 1;
   localparam int FCNT_BITS   = 2;

   localparam int ADDR_BITS = 4;
   localparam int DATA_BITS = 32;

   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_INV_RATIO = 2'd1;
   localparam logic [1:0] REG_ATTACK    = 2'd2;
   localparam logic [1:0] REG_RELEASE   = 2'd3;

   localparam logic [MAG_BITS-1:0]    THRESHOLD_RESET = 15'd32767;
   localparam logic [WEIGHT_BITS-1:0] INV_RATIO_RESET = 16'd32768;
   localparam logic [WEIGHT_BITS-1:0] ATTACK_RESET    = 16'd60000;
   localparam logic [WEIGHT_BITS-1:0] RELEASE_RESET   = 16'd65000;

   // One classified sample as it waits between the front and the back.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] raw;
      logic                   neg;
      logic [ABS_BITS-1:0]    absval;
      logic [MAG_BITS-1:0]    mag;
      logic                   block_end;
   } edc_item_type;

   typedef struct packed {
      logic [MAG_BITS-1:0]    threshold;
      logic [WEIGHT_BITS-1:0] inv_ratio;
      logic [WEIGHT_BITS-1:0] attack;
      logic [WEIGHT_BITS-1:0] release_w;
   } edc_cfg_type;

   // Handshake between the queue and the back end.
   typedef struct packed {
      logic pop;
   } edc_qctl_type;

endpackage

[rtl/edc_front.sv]
`timescale 1ns / 1ps
// Front end: accepts a sample and classifies it into sign, magnitude and the
// saturated envelope magnitude. Depends on edc_pkg.
module edc_front (
   input  logic [edc_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  logic                            req_block_end_in,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            fifo_full,
   output logic                            fifo_push,
   output edc_pkg::edc_item_type           fifo_item
);
   import edc_pkg::*;

   logic [ABS_BITS-1:0] absval;

   // The most negative sample comes out as 2^(SAMPLE_BITS-1), one above the
   // largest positive sample.
   always_comb begin
      if (req_sample_in[SAMPLE_BITS-1]) begin
         absval = {1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, req_sample_in};
      end else begin
         absval = {1'b0, req_sample_in};
      end
   end

   always_comb begin
      fifo_item.raw       = req_sample_in;
      fifo_item.neg       = req_sample_in[SAMPLE_BITS-1];
      fifo_item.absval    = absval;
      fifo_item.block_end = req_block_end_in;
      if (absval[ABS_BITS-1:MAG_BITS] != 2'b00) begin
         fifo_item.mag = {MAG_BITS{1'b1}};
      end else begin
         fifo_item.mag = absval[MAG_BITS-1:0];
      end
   end

   assign req_full  = fifo_full;
   assign fifo_push = req_push && !fifo_full;

endmodule

[rtl/edc_fifo.sv]
`timescale 1ns / 1ps
// Short queue of classified samples between the front and back ends.
// Depends on edc_pkg.
module edc_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  edc_pkg::edc_item_type wdata,
   output logic                  full,
   input  edc_pkg::edc_qctl_type ctl_in,
   output logic                  empty,
   output edc_pkg::edc_item_type rdata
);
   import edc_pkg::*;

   edc_item_type           entry_ff [FIFO_DEPTH];
   logic [FPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == FCNT_BITS'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = ctl_in.pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[rtl/edc_back.sv]
`timescale 1ns / 1ps
// Back end: envelope follower, gain computation, restoring divider and the
// result register. Depends on edc_pkg.
module edc_back (
   input  logic                               clock,
   input  logic                               reset,
   input  edc_pkg::edc_cfg_type               cfg,
   input  logic                               fifo_empty,
   input  edc_pkg::edc_item_type              fifo_item,
   output edc_pkg::edc_qctl_type              qctl,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [edc_pkg::SAMPLE_BITS-1:0]    rsp_sample_out,
   output logic                               rsp_block_end_out,
   output logic                               rsp_reducing,
   output logic [edc_pkg::MAG_BITS-1:0]       rsp_envelope_level
);
   import edc_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_MUL  = 9'b000000010,
      ST_SUM  = 9'b000000100,
      ST_CMP  = 9'b000001000,
      ST_MULG = 9'b000010000,
      ST_GAIN = 9'b000100000,
      ST_MULN = 9'b001000000,
      ST_DIV  = 9'b010000000,
      ST_DONE = 9'b100000000
   } back_state_type;

   back_state_type          state_ff, state_in;
   edc_item_type            item_ff, item_in;
   logic [ENV_BITS-1:0]     env_ff, env_in;
   logic [WEIGHT_BITS-1:0]  weight_ff, weight_in;
   logic [WPROD_BITS-1:0]   p1_ff, p1_in;
   logic [MPROD_BITS-1:0]   p2_ff, p2_in;
   logic                    red_ff, red_in;
   logic [ENV_BITS-1:0]     diff_ff, diff_in;
   logic [WPROD_BITS-1:0]   pg_ff, pg_in;
   logic [ENV_BITS-1:0]     gain_ff, gain_in;
   logic [ENV_BITS-1:0]     rem_ff, rem_in;
   logic [ABS_BITS-1:0]     nq_ff, nq_in;
   logic [DCNT_BITS-1:0]    cnt_ff, cnt_in;

   logic                    out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0]  out_sample_ff;
   logic                    out_block_end_ff;
   logic                    out_reducing_ff;
   logic [MAG_BITS-1:0]     out_env_ff;

   logic [ENV_BITS-1:0]     mscaled;
   logic [ENV_BITS-1:0]     thr_scaled;
   logic [NUM_BITS-1:0]     env_sum;
   logic [NUM_BITS-1:0]     num;
   logic [ENV_BITS:0]       trial;
   logic                    trial_ge;
   logic [SAMPLE_BITS-1:0]  result;
   logic                    done_fire;

   assign mscaled    = {fifo_item.mag, {ENV_FRAC{1'b0}}};
   assign thr_scaled = {cfg.threshold, {ENV_FRAC{1'b0}}};
   assign env_sum    = {1'b0, p1_ff} + {p2_ff, {ENV_FRAC{1'b0}}}
                     + NUM_BITS'(1 << (WEIGHT_BITS - 1));
   assign num        = {{(NUM_BITS-ABS_BITS){1'b0}}, item_ff.absval}
                     * {{(NUM_BITS-ENV_BITS){1'b0}}, gain_ff};
   assign trial      = {rem_ff, nq_ff[ABS_BITS-1]};
   assign trial_ge   = (trial >= {1'b0, env_ff});
   assign done_fire  = (state_ff == ST_DONE) && (!out_valid_ff || rsp_pop);

   always_comb begin
      if (!red_ff) begin
         result = item_ff.raw;
      end else if (item_ff.neg) begin
         result = SAMPLE_BITS'(~nq_ff + 1'b1);
      end else begin
         result = nq_ff[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      env_in    = env_ff;
      weight_in = weight_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      red_in    = red_ff;
      diff_in   = diff_ff;
      pg_in     = pg_ff;
      gain_in   = gain_ff;
      rem_in    = rem_ff;
      nq_in     = nq_ff;
      cnt_in    = cnt_ff;
      qctl.pop  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               qctl.pop  = 1'b1;
               item_in   = fifo_item;
               weight_in = (mscaled > env_ff) ? cfg.attack : cfg.release_w;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            p1_in = {{ENV_BITS{1'b0}}, weight_ff} * {{WEIGHT_BITS{1'b0}}, env_ff};
            p2_in = {{MAG_BITS{1'b0}}, ({1'b1, {WEIGHT_BITS{1'b0}}} - {1'b0, weight_ff})}
                  * {{(WEIGHT_BITS+1){1'b0}}, item_ff.mag};
            state_in = ST_SUM;
         end
         ST_SUM: begin
            env_in   = env_sum[WEIGHT_BITS +: ENV_BITS];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            red_in   = (env_ff > thr_scaled);
            diff_in  = env_ff - thr_scaled;
            state_in = (env_ff > thr_scaled) ? ST_MULG : ST_DONE;
         end
         ST_MULG: begin
            pg_in = {{WEIGHT_BITS{1'b0}}, diff_ff} * {{ENV_BITS{1'b0}}, cfg.inv_ratio};
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            gain_in  = thr_scaled + pg_ff[WEIGHT_BITS +: ENV_BITS];
            state_in = ST_MULN;
         end
         ST_MULN: begin
            rem_in   = num[NUM_BITS-1:ABS_BITS];
            nq_in    = num[ABS_BITS-1:0];
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (trial_ge) begin
               rem_in = ENV_BITS'(trial - {1'b0, env_ff});
            end else begin
               rem_in = trial[ENV_BITS-1:0];
            end
            nq_in  = {nq_ff[ABS_BITS-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DCNT_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (done_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         env_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         env_ff       <= env_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      weight_ff <= weight_in;
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      red_ff    <= red_in;
      diff_ff   <= diff_in;
      pg_ff     <= pg_in;
      gain_ff   <= gain_in;
      rem_ff    <= rem_in;
      nq_ff     <= nq_in;
      cnt_ff    <= cnt_in;
      if (done_fire) begin
         out_sample_ff    <= result;
         out_block_end_ff <= item_ff.block_end;
         out_reducing_ff  <= red_ff;
         out_env_ff       <= env_ff[ENV_FRAC +: MAG_BITS];
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_sample_out     = out_sample_ff;
   assign rsp_block_end_out  = out_block_end_ff;
   assign rsp_reducing       = out_reducing_ff;
   assign rsp_envelope_level = out_env_ff;

endmodule

[rtl/envelope_dynamic_compressor.sv]
`timescale 1ns / 1ps
// Top level of the envelope dynamic compressor: register port, front end, queue
// and back end. Depends on edc_pkg, edc_front, edc_fifo and edc_back.

// Feed-forward peak-envelope compressor for signed Q1.15 samples. Each
// sample's magnitude, saturated to 32767, drives a one-pole envelope that
// uses the attack weight while the magnitude is above the envelope and the
// release weight otherwise. When the updated envelope is above the threshold,
// the sample is scaled by gain/envelope with gain = threshold +
// (envelope - threshold) * inverse_ratio, truncated toward zero; otherwise it
// passes unchanged. The restoring divider in the back end produces one quotient
// bit per cycle. A two-entry queue between the front end and the back end takes
// new samples while the back end works, and a result register holds a finished
// transfer until it is popped, so the back end only waits when that register is
// still full. Registers sit at byte addresses 0 (threshold), 4 (inverse ratio),
// 8 (attack weight) and 12 (release weight); they should be written only while
// no sample is in flight.
module envelope_dynamic_compressor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [edc_pkg::SAMPLE_BITS-1:0]   req_sample_in,
   input  logic                              req_block_end_in,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [edc_pkg::SAMPLE_BITS-1:0]   rsp_sample_out,
   output logic                              rsp_block_end_out,
   output logic                              rsp_reducing,
   output logic [edc_pkg::MAG_BITS-1:0]      rsp_envelope_level,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [edc_pkg::ADDR_BITS-1:0]     csr_paddr,
   input  logic [edc_pkg::DATA_BITS-1:0]     csr_pwdata,
   output logic [edc_pkg::DATA_BITS-1:0]     csr_prdata,
   output logic                              csr_pready
);
   import edc_pkg::*;

   // Configuration registers.
   logic [MAG_BITS-1:0]    threshold_ff;
   logic [WEIGHT_BITS-1:0] inv_ratio_ff;
   logic [WEIGHT_BITS-1:0] attack_ff;
   logic [WEIGHT_BITS-1:0] release_ff;
   logic                   csr_write;
   logic [1:0]             csr_index;
   edc_cfg_type            cfg;

   // Links between the parts.
   logic                   fifo_full;
   logic                   fifo_push;
   edc_item_type           push_item;
   edc_item_type           head_item;
   logic                   fifo_empty;
   edc_qctl_type           qctl;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   // Bits above a register's width are dropped on a write.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         inv_ratio_ff <= INV_RATIO_RESET;
         attack_ff    <= ATTACK_RESET;
         release_ff   <= RELEASE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_THRESHOLD: threshold_ff <= csr_pwdata[MAG_BITS-1:0];
            REG_INV_RATIO: inv_ratio_ff <= csr_pwdata[WEIGHT_BITS-1:0];
            REG_ATTACK:    attack_ff    <= csr_pwdata[WEIGHT_BITS-1:0];
            REG_RELEASE:   release_ff   <= csr_pwdata[WEIGHT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_THRESHOLD: csr_prdata = {{(DATA_BITS-MAG_BITS){1'b0}}, threshold_ff};
         REG_INV_RATIO: csr_prdata = {{(DATA_BITS-WEIGHT_BITS){1'b0}}, inv_ratio_ff};
         REG_ATTACK:    csr_prdata = {{(DATA_BITS-WEIGHT_BITS){1'b0}}, attack_ff};
         REG_RELEASE:   csr_prdata = {{(DATA_BITS-WEIGHT_BITS){1'b0}}, release_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.threshold = threshold_ff;
   assign cfg.inv_ratio = inv_ratio_ff;
   assign cfg.attack    = attack_ff;
   assign cfg.release_w = release_ff;

   // The front end classifies each incoming sample in the cycle of its
   // transfer and drops it into the queue.
   edc_front u_front (
      .req_sample_in    (req_sample_in),
      .req_block_end_in (req_block_end_in),
      .req_push         (req_push),
      .req_full         (req_full),
      .fifo_full        (fifo_full),
      .fifo_push        (fifo_push),
      .fifo_item        (push_item)
   );

   edc_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (fifo_push),
      .wdata  (push_item),
      .full   (fifo_full),
      .ctl_in (qctl),
      .empty  (fifo_empty),
      .rdata  (head_item)
   );

   // The back end owns the envelope and works through one sample at a time.
   edc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .fifo_empty         (fifo_empty),
      .fifo_item          (head_item),
      .qctl               (qctl),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_sample_out     (rsp_sample_out),
      .rsp_block_end_out  (rsp_block_end_out),
      .rsp_reducing       (rsp_reducing),
      .rsp_envelope_level (rsp_envelope_level)
   );

   // The back end never takes a sample from an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      qctl.pop |-> !fifo_empty)
      else $error("back end popped an empty queue");

   // A reducing result carries an envelope at or above the threshold.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_reducing) |-> (rsp_envelope_level >= threshold_ff))
      else $error("reducing result with envelope below threshold");

   // A result without gain carries an envelope at or below the threshold.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_reducing) |-> (rsp_envelope_level <= threshold_ff))
      else $error("unreduced result with envelope above threshold");

endmodule

[tb/envelope_dynamic_compressor_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the envelope dynamic compressor: table-driven directed
// samples, then bursts of random audio under several register settings. Depends on edc_pkg.
module envelope_dynamic_compressor_test;
   import edc_pkg::*;

   // Fixed-point constants of the gain computer, taken from the package widths.
   localparam longint unsigned WEIGHT_ONE  = 64'd1 << WEIGHT_BITS;
   localparam longint unsigned SAMPLE_SPAN = 64'd1 << SAMPLE_BITS;
   localparam longint unsigned MAG_MAX     = (64'd1 << MAG_BITS) - 1;
   localparam int DIRECTED_ROWS = 24;
   localparam int SEGMENTS      = 10;
   localparam int SEGMENT_ITEMS = 120;
   // Settling time after draining; it covers the back end's slowest sample with margin.
   localparam int SETTLE_CYCLES = 40;

   // One result transfer as it leaves the block.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_out;
      logic                   block_end;
      logic                   reducing;
      logic [MAG_BITS-1:0]    level;
   } comp_result_type;

   // One row of the directed table. When new_setting is set, the four registers are
   // rewritten before the sample goes in. Rows with typed set carry their own
   // expected result; the others are checked against the gain computer below.
   typedef struct packed {
      bit                   new_setting;
      bit [MAG_BITS-1:0]    thr;
      bit [WEIGHT_BITS-1:0] ratio;
      bit [WEIGHT_BITS-1:0] attack;
      bit [WEIGHT_BITS-1:0] release_w;
      shortint              sample;
      bit                   blk;
      bit                   typed;
      shortint              x_sample;
      bit                   x_red;
      bit [MAG_BITS-1:0]    x_level;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_push;
   logic                   req_full;
   logic [SAMPLE_BITS-1:0] req_sample_in;
   logic                   req_block_end_in;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                   rsp_block_end_out;
   logic                   rsp_reducing;
   logic [MAG_BITS-1:0]    rsp_envelope_level;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [ADDR_BITS-1:0]   csr_paddr;
   logic [DATA_BITS-1:0]   csr_pwdata;
   logic [DATA_BITS-1:0]   csr_prdata;
   logic                   csr_pready;

   // Shadow copy of the registers and of the envelope, as the gain computer sees them.
   logic [MAG_BITS-1:0]    cfg_threshold = THRESHOLD_RESET;
   logic [WEIGHT_BITS-1:0] cfg_inv_ratio = INV_RATIO_RESET;
   logic [WEIGHT_BITS-1:0] cfg_attack    = ATTACK_RESET;
   logic [WEIGHT_BITS-1:0] cfg_release   = RELEASE_RESET;
   longint unsigned        env_track     = 0;

   comp_result_type pending_results[$];
   int unsigned  mismatch_count = 0;
   int unsigned  results_seen   = 0;
   // While set, neither side inserts random gaps; the pop side still makes its long holds.
   bit           no_idle        = 1'b0;

   // Directed table. The first block runs at the reset settings. With both weights at
   // zero the envelope equals the magnitude of the sample at once, so the typed rows
   // can be read straight off the arithmetic: a maximum threshold never reduces, and a
   // zero threshold with a zero inverse ratio drives every nonzero sample to zero.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{0,     0,     0,     0,     0,      0, 0, 1,      0, 0,     0},
      '{0,     0,     0,     0,     0,  32767, 0, 0,      0, 0,     0},
      '{0,     0,     0,     0,     0, -32768, 1, 0,      0, 0,     0},
      '{0,     0,     0,     0,     0,     -1, 0, 0,      0, 0,     0},
      '{1, 32767, 32768,     0,     0,  32767, 0, 1,  32767, 0, 32767},
      '{0,     0,     0,     0,     0, -32768, 1, 1, -32768, 0, 32767},
      '{0,     0,     0,     0,     0,      0, 0, 1,      0, 0,     0},
      '{0,     0,     0,     0,     0,      1, 0, 1,      1, 0,     1},
      '{1,     0,     0,     0,     0,  12345, 0, 1,      0, 1, 12345},
      '{0,     0,     0,     0,     0, -32768, 0, 1,      0, 1, 32767},
      '{0,     0,     0,     0,     0,      0, 1, 1,      0, 0,     0},
      '{0,     0,     0,     0,     0,     -1, 1, 1,      0, 1,     1},
      '{1,     0, 65535,     0,     0,  32767, 0, 0,      0, 0,     0},
      '{0,     0,     0,     0,     0, -32768, 0, 0,      0, 0,     0},
      '{0,     0,     0,     0,     0,    100, 1, 0,      0, 0,     0},
      '{1, 16384, 16384, 65535, 65535,  32767, 0, 0,      0, 0,     0},
      '{0,     0,     0,     0,     0,  32767, 0, 0,      0, 0,     0},
      '{0,     0,     0,     0,     0, -32768, 0, 0,      0, 0,     0},
      '{1,  1000, 32768, 30000, 64000,  30000, 0, 0,      0, 0,     0},
      '{0,     0,     0,     0,     0, -30000, 0, 0,      0, 0,     0},
      '{0,     0,     0,     0,     0,    500, 1, 0,      0, 0,     0},
      '{0,     0,     0,     0,     0, -32768, 0, 0,      0, 0,     0},
      '{0,     0,     0,     0,     0,  32767, 0, 0,      0, 0,     0},
      '{0,     0,     0,     0,     0,      0, 1, 0,      0, 0,     0}
   };

   envelope_dynamic_compressor dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_sample_in      (req_sample_in),
      .req_block_end_in   (req_block_end_in),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_sample_out     (rsp_sample_out),
      .rsp_block_end_out  (rsp_block_end_out),
      .rsp_reducing       (rsp_reducing),
      .rsp_envelope_level (rsp_envelope_level),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Independent time limit, several times the slowest legal run.
   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Gain computer: updates the envelope with the weight picked by the direction of
   // the magnitude, then scales the sample by gain/envelope when above threshold.
   // The most negative sample saturates for the envelope but divides with its true
   // magnitude, which is why absval and mag are kept apart.
   function automatic comp_result_type compress_sample(input logic [SAMPLE_BITS-1:0] s,
                                                       input logic blk);
      comp_result_type res;
      longint unsigned raw, absval, mag, mscaled, weight, thr, gain, quot, outval;
      bit              neg;
      raw     = s;
      neg     = s[SAMPLE_BITS-1];
      absval  = neg ? SAMPLE_SPAN - raw : raw;
      mag     = (absval > MAG_MAX) ? MAG_MAX : absval;
      mscaled = mag << ENV_FRAC;
      weight  = (mscaled > env_track) ? cfg_attack : cfg_release;
      env_track = (weight * env_track + (WEIGHT_ONE - weight) * mscaled
                   + (WEIGHT_ONE >> 1)) >> WEIGHT_BITS;
      thr    = longint'(cfg_threshold) << ENV_FRAC;
      outval = raw;
      res.reducing = (env_track > thr);
      if (res.reducing) begin
         gain   = thr + (((env_track - thr) * cfg_inv_ratio) >> WEIGHT_BITS);
         quot   = (absval * gain) / env_track;
         outval = neg ? (SAMPLE_SPAN - quot) % SAMPLE_SPAN : quot;
      end
      res.sample_out = outval[SAMPLE_BITS-1:0];
      res.block_end  = blk;
      res.level      = env_track[ENV_FRAC +: MAG_BITS];
      return res;
   endfunction

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 20);
      return $urandom_range(30, 120);
   endfunction

   function automatic logic [DATA_BITS-1:0] reg_shadow(input logic [1:0] idx);
      case (idx)
         REG_THRESHOLD: return DATA_BITS'(cfg_threshold);
         REG_INV_RATIO: return DATA_BITS'(cfg_inv_ratio);
         REG_ATTACK:    return DATA_BITS'(cfg_attack);
         default:       return DATA_BITS'(cfg_release);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                  input logic [31:0] act_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
   endtask

   // One register transfer: setup cycle, then access cycle. Entered at a falling
   // edge and left at a falling edge where nothing has been driven yet.
   task automatic csr_access(input bit is_write, input logic [1:0] idx,
                             input logic [DATA_BITS-1:0] wdata,
                             output logic [DATA_BITS-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Bits above the register width carry random junk that the block must drop.
   task automatic write_reg(input logic [1:0] idx, input logic [WEIGHT_BITS-1:0] value);
      logic [DATA_BITS-1:0] junk, rd;
      junk = $urandom;
      csr_access(1'b1, idx, {junk[DATA_BITS-1:WEIGHT_BITS], value}, rd);
      case (idx)
         REG_THRESHOLD: cfg_threshold = value[MAG_BITS-1:0];
         REG_INV_RATIO: cfg_inv_ratio = value;
         REG_ATTACK:    cfg_attack    = value;
         REG_RELEASE:   cfg_release   = value;
         default: ;
      endcase
   endtask

   task automatic verify_reg(input logic [1:0] idx);
      logic [DATA_BITS-1:0] rd;
      csr_access(1'b0, idx, '0, rd);
      if (rd !== reg_shadow(idx))
         report_mismatch("register read", reg_shadow(idx), rd);
   endtask

   task automatic check_readback();
      verify_reg(REG_THRESHOLD);
      verify_reg(REG_INV_RATIO);
      verify_reg(REG_ATTACK);
      verify_reg(REG_RELEASE);
   endtask

   task automatic apply_setting(input logic [MAG_BITS-1:0] thr,
                                input logic [WEIGHT_BITS-1:0] ratio,
                                input logic [WEIGHT_BITS-1:0] att,
                                input logic [WEIGHT_BITS-1:0] rel);
      write_reg(REG_THRESHOLD, {1'($urandom), thr});
      write_reg(REG_INV_RATIO, ratio);
      write_reg(REG_ATTACK, att);
      write_reg(REG_RELEASE, rel);
      check_readback();
   endtask

   // Stops offering samples and waits until every expected result has been popped,
   // then lets the back end settle so the block is idle for register writes.
   task automatic drain();
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Offers one sample, entered at a falling edge. The expectation is queued at the
   // edge where the transfer happens. The push stays high when no gap follows, so
   // back-to-back transfers never lower and raise it in one time step.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic blk,
                              input bit use_typed, input comp_result_type typed_res);
      comp_result_type predicted;
      int unsigned  gap;
      req_push         <= 1'b1;
      req_sample_in    <= s;
      req_block_end_in <= blk;
      do @(posedge clock); while (req_full !== 1'b0);
      predicted = compress_sample(s, blk);
      pending_results.push_back(use_typed ? typed_res : predicted);
      @(negedge clock);
      gap = no_idle ? 0 : pick_gap();
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic [MAG_BITS-1:0] draw_threshold();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return MAG_BITS'(MAG_MAX);
         2, 3:    return MAG_BITS'($urandom_range(1, 3000));
         default: return MAG_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] draw_weight();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return WEIGHT_BITS'($urandom);
      endcase
   endfunction

   // Audio-like content: the loudness class holds for a burst so the envelope has
   // time to rise above the threshold and fall back again.
   function automatic logic [SAMPLE_BITS-1:0] draw_sample(input int unsigned loudness);
      int unsigned m;
      if ($urandom_range(0, 99) < 5) begin
         case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'h0001;
         endcase
      end
      if (loudness == 3) return SAMPLE_BITS'($urandom);
      case (loudness)
         0:       m = $urandom_range(16384, 32767);
         1:       m = $urandom_range(2048, 16383);
         default: m = $urandom_range(0, 2047);
      endcase
      return $urandom_range(0, 1) ? SAMPLE_BITS'(-int'(m)) : SAMPLE_BITS'(m);
   endfunction

   // Result checker: every popped transfer is matched field by field against the
   // oldest expectation.
   initial begin
      comp_result_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_pop === 1'b1 && rsp_empty === 1'b0) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               report_mismatch("result with nothing expected", '0, rsp_sample_out);
            end else begin
               want = pending_results.pop_front();
               if (rsp_sample_out !== want.sample_out)
                  report_mismatch("sample_out", want.sample_out, rsp_sample_out);
               if (rsp_block_end_out !== want.block_end)
                  report_mismatch("block_end_out", want.block_end, rsp_block_end_out);
               if (rsp_reducing !== want.reducing)
                  report_mismatch("reducing", want.reducing, rsp_reducing);
               if (rsp_envelope_level !== want.level)
                  report_mismatch("envelope_level", want.level, rsp_envelope_level);
            end
         end
      end
   end

   // Pop side. Besides random stalls, the receiver holds off for a long stretch every
   // few hundred results while the sender keeps pushing, so the internal queue and
   // the result register fill up and req_full has to rise.
   initial begin
      int unsigned hold_cycles, next_hold_at, gap;
      rsp_pop      = 1'b0;
      hold_cycles  = 0;
      next_hold_at = 200;
      forever begin
         @(negedge clock);
         if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_pop <= 1'b0;
         end else if (results_seen >= next_hold_at) begin
            hold_cycles  = 300;
            next_hold_at = next_hold_at + 450;
            rsp_pop <= 1'b0;
         end else if (no_idle) begin
            rsp_pop <= 1'b1;
         end else begin
            gap = pick_gap();
            if (gap == 0) begin
               rsp_pop <= 1'b1;
            end else begin
               rsp_pop <= 1'b0;
               hold_cycles = gap - 1;
            end
         end
      end
   end

   // Main sequence: reset, register reset values, directed table, random segments.
   initial begin
      comp_result_type typed_res;
      stim_row_type    row;
      int unsigned     loudness, burst_left;
      logic            blk;
      reset            = 1'b1;
      req_push         = 1'b0;
      req_sample_in    = '0;
      req_block_end_in = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      check_readback();

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.new_setting) begin
            drain();
            apply_setting(row.thr, row.ratio, row.attack, row.release_w);
         end
         typed_res.sample_out = row.x_sample;
         typed_res.block_end  = row.blk;
         typed_res.reducing   = row.x_red;
         typed_res.level      = row.x_level;
         send_sample(row.sample, row.blk, row.typed, typed_res);
      end

      // Random part: each segment runs under its own register setting, and every
      // fourth segment runs without random gaps on either side.
      burst_left = 0;
      loudness   = 0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         apply_setting(draw_threshold(), draw_weight(), draw_weight(), draw_weight());
         no_idle = (seg % 4 == 3);
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            if (burst_left == 0) begin
               loudness   = $urandom_range(0, 3);
               burst_left = $urandom_range(10, 60);
            end
            burst_left--;
            blk = ($urandom_range(0, 15) == 0);
            send_sample(draw_sample(loudness), blk, 1'b0, '0);
         end
         no_idle = 1'b0;
      end

      drain();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[envelope_dynamic_compressor.f]
rtl/edc_pkg.sv
rtl/edc_front.sv
rtl/edc_fifo.sv
rtl/edc_back.sv
rtl/envelope_dynamic_compressor.sv
tb/envelope_dynamic_compressor_test.sv
